// ===== design/hpfg_pkg.sv =====
// Package for the homography floor-grid mapper.
// Holds shared widths, constants, config register codes and the sideband structs.
// No dependencies.
package hpfg_pkg;

    // Internal point: unsigned Q16.1, saturated at 2 * 65535
    localparam int PIX_W = 17;
    localparam logic [PIX_W-1:0] PIX_SAT = 17'd131070;

    localparam int IN_W    = 16;
    localparam int FLOOR_W = 32;
    localparam int CELL_W  = 12;
    localparam int ROW_W   = 63;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    // Ratio divider quotient bits (result below 2^31, overflow flagged separately)
    localparam int RATIO_QB = 31;
    localparam int FRAC_SH  = 16;

    // Uncalibrated mode: (p * 2^16 + 1600) / 3200 equals (p * 1024 + 25) / 50
    localparam int UNCAL_DEN = 3200;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ROW0    = 3'd0,
        CFG_ROW1    = 3'd1,
        CFG_ROW2    = 3'd2,
        CFG_CALIB   = 3'd3,
        CFG_FLOOR_W = 3'd4,
        CFG_FLOOR_H = 3'd5,
        CFG_GRID    = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [ROW_W-1:0]   row0;
        logic [ROW_W-1:0]   row1;
        logic [ROW_W-1:0]   row2;
        logic               calibrated;
        logic [FLOOR_W-1:0] floor_w;
        logic [FLOOR_W-1:0] floor_h;
        logic [12:0]        grid;
    } t_cfg;

    // Sideband through the ratio dividers
    typedef struct packed {
        logic neg_x;
        logic ovf_x;
        logic neg_z;
        logic ovf_z;
        logic degen;
    } t_ratio_tag;

    // Sideband through the cell dividers
    typedef struct packed {
        logic [FLOOR_W-1:0] fx;
        logic [FLOOR_W-1:0] fz;
        logic               degen;
        logic               zero_x;
        logic               full_x;
        logic               zero_z;
        logic               full_z;
    } t_cell_tag;

endpackage

// ===== design/hpfg_div_pipe.sv =====
// Two-lane pipelined restoring divider, one quotient bit per stage.
// Caller guarantees num < den << QB on each lane. Does not depend on hpfg_pkg.
module hpfg_div_pipe #(
    parameter int VW = 39,
    parameter int QB = 31,
    parameter int TW = 5
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_en,
    input  logic             i_valid,
    input  logic [VW+QB-1:0] i_num_a,
    input  logic [VW-1:0]    i_den_a,
    input  logic [VW+QB-1:0] i_num_b,
    input  logic [VW-1:0]    i_den_b,
    input  logic [TW-1:0]    i_tag,
    output logic             o_valid,
    output logic [QB-1:0]    o_quo_a,
    output logic [QB-1:0]    o_quo_b,
    output logic [TW-1:0]    o_tag
);
    localparam int RW = VW + QB;

    logic            r_valid [QB];
    logic [RW-1:0]   r_rem_a [QB];
    logic [RW-1:0]   r_rem_b [QB];
    logic [VW-1:0]   r_den_a [QB];
    logic [VW-1:0]   r_den_b [QB];
    logic [QB-1:0]   r_quo_a [QB];
    logic [QB-1:0]   r_quo_b [QB];
    logic [TW-1:0]   r_tag   [QB];

    for (genvar k = 0; k < QB; k++) begin : g_stage
        localparam int SH = QB - 1 - k;
        logic          w_valid;
        logic [RW-1:0] w_rem_a, w_rem_b, w_sub_a, w_sub_b;
        logic [VW-1:0] w_den_a, w_den_b;
        logic [QB-1:0] w_quo_a, w_quo_b;
        logic [TW-1:0] w_tag;
        logic          w_ge_a, w_ge_b;

        if (k == 0) begin : g_first
            assign w_valid = i_valid;
            assign w_rem_a = i_num_a;
            assign w_rem_b = i_num_b;
            assign w_den_a = i_den_a;
            assign w_den_b = i_den_b;
            assign w_quo_a = '0;
            assign w_quo_b = '0;
            assign w_tag   = i_tag;
        end else begin : g_next
            assign w_valid = r_valid[k-1];
            assign w_rem_a = r_rem_a[k-1];
            assign w_rem_b = r_rem_b[k-1];
            assign w_den_a = r_den_a[k-1];
            assign w_den_b = r_den_b[k-1];
            assign w_quo_a = r_quo_a[k-1];
            assign w_quo_b = r_quo_b[k-1];
            assign w_tag   = r_tag[k-1];
        end

        // trial subtract of the divisor aligned to this quotient bit
        assign w_sub_a = RW'(w_den_a) << SH;
        assign w_sub_b = RW'(w_den_b) << SH;
        assign w_ge_a  = w_rem_a >= w_sub_a;
        assign w_ge_b  = w_rem_b >= w_sub_b;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[k] <= 1'b0;
            end else if (i_en) begin
                r_valid[k] <= w_valid;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem_a[k] <= w_ge_a ? (w_rem_a - w_sub_a) : w_rem_a;
                r_rem_b[k] <= w_ge_b ? (w_rem_b - w_sub_b) : w_rem_b;
                r_quo_a[k] <= {w_quo_a[QB-2:0], w_ge_a};
                r_quo_b[k] <= {w_quo_b[QB-2:0], w_ge_b};
                r_den_a[k] <= w_den_a;
                r_den_b[k] <= w_den_b;
                r_tag[k]   <= w_tag;
            end
        end
    end

    assign o_valid = r_valid[QB-1];
    assign o_quo_a = r_quo_a[QB-1];
    assign o_quo_b = r_quo_b[QB-1];
    assign o_tag   = r_tag[QB-1];

endmodule

// ===== design/hpfg_front.sv =====
// Front end: point formation, homography dot products and ratio dividend setup.
// Six register stages; depends on hpfg_pkg.
module hpfg_front import hpfg_pkg::*; #(
    parameter int COEF_BITS = 21
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_en,
    input  t_cfg                                 i_cfg,
    input  logic                                 i_valid,
    input  logic                                 i_req_type,
    input  logic [IN_W-1:0]                      i_pixel_x,
    input  logic [IN_W-1:0]                      i_pixel_y,
    input  logic [IN_W-1:0]                      i_box_width,
    input  logic [IN_W-1:0]                      i_box_height,
    output logic                                 o_valid,
    output logic [COEF_BITS+PIX_W+RATIO_QB:0]    o_num_x,
    output logic [COEF_BITS+PIX_W+RATIO_QB:0]    o_num_z,
    output logic [COEF_BITS+PIX_W:0]             o_den,
    output t_ratio_tag                           o_tag
);
    localparam int DW = COEF_BITS + PIX_W + 2;   // signed dot product
    localparam int AW = DW - 1;                  // magnitude
    localparam int RW = AW + RATIO_QB;           // dividend
    localparam int PW = COEF_BITS + PIX_W + 1;   // one product

    // valid bits, one per stage
    logic [5:0] r_v;

    // stage 0: point
    logic [PIX_W-1:0] r0_px, r0_py;
    logic [PIX_W:0]   w_bx, w_by;

    assign w_bx = {1'b0, i_pixel_x, 1'b0} + (PIX_W+1)'(i_box_width);
    assign w_by = {1'b0, i_pixel_y, 1'b0} + {1'b0, i_box_height, 1'b0};

    // stage 1: products
    logic signed [COEF_BITS-1:0] w_c [3][3];
    logic [ROW_W-1:0]            w_row [3];
    logic signed [PW-1:0]        r1_m0 [3];
    logic signed [PW-1:0]        r1_m1 [3];
    logic signed [COEF_BITS-1:0] r1_c2 [3];
    logic [PIX_W-1:0]            r1_px, r1_py;

    assign w_row[0] = i_cfg.row0;
    assign w_row[1] = i_cfg.row1;
    assign w_row[2] = i_cfg.row2;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            for (int k = 0; k < 3; k++) begin
                w_c[r][k] = $signed(w_row[r][k*COEF_BITS +: COEF_BITS]);
            end
        end
    end

    // stage 2: row sums
    logic signed [DW-1:0] w_dot [3];
    logic signed [DW-1:0] r2_dot [3];
    logic [PIX_W-1:0]     r2_px, r2_py;

    always_comb begin
        for (int r = 0; r < 3; r++) begin
            w_dot[r] = DW'(r1_m0[r]) + DW'(r1_m1[r]) + (DW'(r1_c2[r]) <<< 5);
        end
    end

    // stage 3: signs and magnitudes
    logic [AW-1:0] r3_un_x, r3_un_z, r3_ud;
    t_ratio_tag    r3_tag;
    logic          w_nx, w_nz, w_nd;

    assign w_nx = r2_dot[0][DW-1];
    assign w_nz = r2_dot[1][DW-1];
    assign w_nd = r2_dot[2][DW-1];

    // stage 4: dividends
    logic [RW-1:0] r4_d_x, r4_d_z;
    logic [AW-1:0] r4_ud;
    t_ratio_tag    r4_tag;

    // stage 5: overflow check
    logic [RW-1:0] w_lim;
    logic          w_ovf_x, w_ovf_z;
    logic [RW-1:0] r5_d_x, r5_d_z;
    logic [AW-1:0] r5_ud;
    t_ratio_tag    r5_tag;

    assign w_lim   = RW'(r4_ud) << RATIO_QB;
    assign w_ovf_x = r4_d_x >= w_lim;
    assign w_ovf_z = r4_d_z >= w_lim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // bottom centre of a box saturates per axis
            if (i_req_type) begin
                r0_px <= (w_bx > (PIX_W+1)'(PIX_SAT)) ? PIX_SAT : w_bx[PIX_W-1:0];
                r0_py <= (w_by > (PIX_W+1)'(PIX_SAT)) ? PIX_SAT : w_by[PIX_W-1:0];
            end else begin
                r0_px <= {i_pixel_x, 1'b0};
                r0_py <= {i_pixel_y, 1'b0};
            end

            for (int r = 0; r < 3; r++) begin
                r1_m0[r] <= w_c[r][0] * $signed({1'b0, r0_px});
                r1_m1[r] <= w_c[r][1] * $signed({1'b0, r0_py});
                r1_c2[r] <= w_c[r][2];
            end
            r1_px <= r0_px;
            r1_py <= r0_py;

            r2_dot <= w_dot;
            r2_px  <= r1_px;
            r2_py  <= r1_py;

            if (i_cfg.calibrated) begin
                r3_un_x      <= w_nx ? AW'(-r2_dot[0]) : AW'(r2_dot[0]);
                r3_un_z      <= w_nz ? AW'(-r2_dot[1]) : AW'(r2_dot[1]);
                r3_ud        <= w_nd ? AW'(-r2_dot[2]) : AW'(r2_dot[2]);
                r3_tag.neg_x <= w_nx ^ w_nd;
                r3_tag.neg_z <= w_nz ^ w_nd;
                r3_tag.degen <= (r2_dot[2] == '0);
            end else begin
                r3_un_x      <= AW'(r2_px);
                r3_un_z      <= AW'(r2_py);
                r3_ud        <= AW'(UNCAL_DEN);
                r3_tag.neg_x <= 1'b0;
                r3_tag.neg_z <= 1'b0;
                r3_tag.degen <= 1'b0;
            end
            r3_tag.ovf_x <= 1'b0;
            r3_tag.ovf_z <= 1'b0;

            // round to nearest: add half the divisor
            r4_d_x <= (RW'(r3_un_x) << FRAC_SH) + RW'(r3_ud >> 1);
            r4_d_z <= (RW'(r3_un_z) << FRAC_SH) + RW'(r3_ud >> 1);
            r4_ud  <= r3_ud;
            r4_tag <= r3_tag;

            // overflowing or degenerate lanes divide zero
            r5_d_x       <= (w_ovf_x || r4_tag.degen) ? '0 : r4_d_x;
            r5_d_z       <= (w_ovf_z || r4_tag.degen) ? '0 : r4_d_z;
            r5_ud        <= r4_ud;
            r5_tag.neg_x <= r4_tag.neg_x;
            r5_tag.ovf_x <= w_ovf_x;
            r5_tag.neg_z <= r4_tag.neg_z;
            r5_tag.ovf_z <= w_ovf_z;
            r5_tag.degen <= r4_tag.degen;
        end
    end

    assign o_valid = r_v[5];
    assign o_num_x = r5_d_x;
    assign o_num_z = r5_d_z;
    assign o_den   = r5_ud;
    assign o_tag   = r5_tag;

endmodule

// ===== design/hpfg_post.sv =====
// Ratio post-processing (sign, saturation) and grid cell dividend setup.
// Two register stages; depends on hpfg_pkg.
module hpfg_post import hpfg_pkg::*; #(
    parameter int GB = 13,
    parameter int QB = 12
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_en,
    input  t_cfg                       i_cfg,
    input  logic [GB-1:0]              i_grid,
    input  logic                       i_valid,
    input  logic [RATIO_QB-1:0]        i_quo_x,
    input  logic [RATIO_QB-1:0]        i_quo_z,
    input  t_ratio_tag                 i_tag,
    output logic                       o_valid,
    output logic [FLOOR_W+QB-1:0]      o_num_x,
    output logic [FLOOR_W+QB-1:0]      o_num_z,
    output t_cell_tag                  o_tag
);
    localparam int RW = FLOOR_W + QB;

    logic [1:0] r_v;

    // stage P: signed, saturated floor coordinates
    logic [FLOOR_W-1:0] r_fx, r_fz;
    logic               r_degen;

    function automatic logic [FLOOR_W-1:0] f_coord(logic [RATIO_QB-1:0] q, logic neg,
                                                   logic ovf, logic degen);
        logic [FLOOR_W-1:0] mag;
        mag = {1'b0, q};
        if (degen)      return '0;
        else if (ovf)   return neg ? {1'b1, {(FLOOR_W-1){1'b0}}} : {1'b0, {(FLOOR_W-1){1'b1}}};
        else if (neg)   return FLOOR_W'(0) - mag;
        else            return mag;
    endfunction

    // stage M: cell products and the clamp cases
    logic [FLOOR_W-2+GB:0] w_prod_x, w_prod_z;
    logic                  w_zero_x, w_zero_z, w_full_x, w_full_z;
    logic [RW-1:0]         r_num_x, r_num_z;
    t_cell_tag             r_tag;

    assign w_prod_x = r_fx[FLOOR_W-2:0] * i_grid;
    assign w_prod_z = r_fz[FLOOR_W-2:0] * i_grid;
    assign w_zero_x = (i_grid == '0) || r_fx[FLOOR_W-1] || (r_fx == '0);
    assign w_zero_z = (i_grid == '0) || r_fz[FLOOR_W-1] || (r_fz == '0);
    assign w_full_x = (i_cfg.floor_w == '0) || (r_fx >= i_cfg.floor_w);
    assign w_full_z = (i_cfg.floor_h == '0) || (r_fz >= i_cfg.floor_h);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (i_en) begin
            r_v <= {r_v[0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_fx    <= f_coord(i_quo_x, i_tag.neg_x, i_tag.ovf_x, i_tag.degen);
            r_fz    <= f_coord(i_quo_z, i_tag.neg_z, i_tag.ovf_z, i_tag.degen);
            r_degen <= i_tag.degen;

            r_num_x      <= (w_zero_x || w_full_x) ? '0 : RW'(w_prod_x);
            r_num_z      <= (w_zero_z || w_full_z) ? '0 : RW'(w_prod_z);
            r_tag.fx     <= r_fx;
            r_tag.fz     <= r_fz;
            r_tag.degen  <= r_degen;
            r_tag.zero_x <= w_zero_x;
            r_tag.full_x <= w_full_x;
            r_tag.zero_z <= w_zero_z;
            r_tag.full_z <= w_full_z;
        end
    end

    assign o_valid = r_v[1];
    assign o_num_x = r_num_x;
    assign o_num_z = r_num_z;
    assign o_tag   = r_tag;

endmodule

// ===== design/homography_point_to_floor_grid.sv =====
// Top level of the homography floor-grid mapper: config registers and pipeline.
// Depends on hpfg_pkg, hpfg_front, hpfg_div_pipe and hpfg_post.
//
// Maps each image point or box bottom centre to floor coordinates (Q15.16,
// through the homography or pixels / 1600) and grid cells. The block is a
// single stall-controlled pipeline: one item enters every cycle unless stalled
// and passes the front end, ratio divider, post stage, cell divider and
// output register in order. A one-entry skid register behind the output
// takes the next result while the receiver stalls, so o_in_stall comes
// straight from a register; the whole pipeline holds only while that skid
// entry is full. Config is written through a separate always-ready port;
// the user must write it only while idle, which the block does not enforce.
module homography_point_to_floor_grid import hpfg_pkg::*; #(
    parameter int COEF_BITS = 21,
    parameter int MAX_GRID  = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_req_type,
    input  logic [IN_W-1:0]       i_pixel_x,
    input  logic [IN_W-1:0]       i_pixel_y,
    input  logic [IN_W-1:0]       i_box_width,
    input  logic [IN_W-1:0]       i_box_height,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [FLOOR_W-1:0]    o_floor_x,
    output logic [FLOOR_W-1:0]    o_floor_z,
    output logic [CELL_W-1:0]     o_cell_x,
    output logic [CELL_W-1:0]     o_cell_z,
    output logic                  o_degenerate
);
    localparam int AW = COEF_BITS + PIX_W + 1;
    localparam int GB = $clog2(MAX_GRID + 1);
    localparam int QB = $clog2(MAX_GRID);

    // config registers
    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.row0       <= '0;
            r_cfg.row1       <= '0;
            r_cfg.row2       <= '0;
            r_cfg.calibrated <= 1'b0;
            r_cfg.floor_w    <= FLOOR_W'(65536);
            r_cfg.floor_h    <= FLOOR_W'(65536);
            r_cfg.grid       <= 13'd1;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_ROW0:    r_cfg.row0       <= i_cfg_data[ROW_W-1:0];
                CFG_ROW1:    r_cfg.row1       <= i_cfg_data[ROW_W-1:0];
                CFG_ROW2:    r_cfg.row2       <= i_cfg_data[ROW_W-1:0];
                CFG_CALIB:   r_cfg.calibrated <= i_cfg_data[0];
                CFG_FLOOR_W: r_cfg.floor_w    <= i_cfg_data[FLOOR_W-1:0];
                CFG_FLOOR_H: r_cfg.floor_h    <= i_cfg_data[FLOOR_W-1:0];
                CFG_GRID:    r_cfg.grid       <= i_cfg_data[12:0];
                default: ;
            endcase
        end
    end

    // grid count limited to MAX_GRID
    logic [17:0]   w_grid_w;
    logic [GB-1:0] w_grid;
    logic [GB-1:0] w_grid_m1;

    assign w_grid_w  = ({5'd0, r_cfg.grid} > 18'(MAX_GRID)) ? 18'(MAX_GRID)
                                                            : {5'd0, r_cfg.grid};
    assign w_grid    = w_grid_w[GB-1:0];
    assign w_grid_m1 = w_grid - GB'(1);

    // global pipeline advance: holds only while the skid entry is full
    logic r_out_valid;
    logic r_sk_valid;
    logic w_out_acc;
    logic w_en;

    assign w_out_acc  = r_out_valid && !i_out_stall;
    assign w_en       = !r_sk_valid;
    assign o_in_stall = r_sk_valid;

    // front end
    logic                   w_f_valid;
    logic [AW+RATIO_QB-1:0] w_f_num_x, w_f_num_z;
    logic [AW-1:0]          w_f_den;
    t_ratio_tag             w_f_tag;

    hpfg_front #(.COEF_BITS(COEF_BITS)) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (w_en),
        .i_cfg        (r_cfg),
        .i_valid      (i_in_valid),
        .i_req_type   (i_req_type),
        .i_pixel_x    (i_pixel_x),
        .i_pixel_y    (i_pixel_y),
        .i_box_width  (i_box_width),
        .i_box_height (i_box_height),
        .o_valid      (w_f_valid),
        .o_num_x      (w_f_num_x),
        .o_num_z      (w_f_num_z),
        .o_den        (w_f_den),
        .o_tag        (w_f_tag)
    );

    // coordinate ratio dividers
    logic                w_r_valid;
    logic [RATIO_QB-1:0] w_r_quo_x, w_r_quo_z;
    t_ratio_tag          w_r_tag;

    hpfg_div_pipe #(.VW(AW), .QB(RATIO_QB), .TW($bits(t_ratio_tag))) u_ratio_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_f_valid),
        .i_num_a (w_f_num_x),
        .i_den_a (w_f_den),
        .i_num_b (w_f_num_z),
        .i_den_b (w_f_den),
        .i_tag   (w_f_tag),
        .o_valid (w_r_valid),
        .o_quo_a (w_r_quo_x),
        .o_quo_b (w_r_quo_z),
        .o_tag   (w_r_tag)
    );

    // saturation and cell products
    logic                  w_p_valid;
    logic [FLOOR_W+QB-1:0] w_p_num_x, w_p_num_z;
    t_cell_tag             w_p_tag;

    hpfg_post #(.GB(GB), .QB(QB)) u_post (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_cfg   (r_cfg),
        .i_grid  (w_grid),
        .i_valid (w_r_valid),
        .i_quo_x (w_r_quo_x),
        .i_quo_z (w_r_quo_z),
        .i_tag   (w_r_tag),
        .o_valid (w_p_valid),
        .o_num_x (w_p_num_x),
        .o_num_z (w_p_num_z),
        .o_tag   (w_p_tag)
    );

    // cell dividers
    logic          w_c_valid;
    logic [QB-1:0] w_c_quo_x, w_c_quo_z;
    t_cell_tag     w_c_tag;

    hpfg_div_pipe #(.VW(FLOOR_W), .QB(QB), .TW($bits(t_cell_tag))) u_cell_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_p_valid),
        .i_num_a (w_p_num_x),
        .i_den_a (r_cfg.floor_w),
        .i_num_b (w_p_num_z),
        .i_den_b (r_cfg.floor_h),
        .i_tag   (w_p_tag),
        .o_valid (w_c_valid),
        .o_quo_a (w_c_quo_x),
        .o_quo_b (w_c_quo_z),
        .o_tag   (w_c_tag)
    );

    // final cell selection with the clamp cases
    logic [CELL_W-1:0] w_cell_x, w_cell_z;

    always_comb begin
        if (w_c_tag.zero_x)      w_cell_x = '0;
        else if (w_c_tag.full_x) w_cell_x = CELL_W'(w_grid_m1);
        else                     w_cell_x = CELL_W'(w_c_quo_x);
        if (w_c_tag.zero_z)      w_cell_z = '0;
        else if (w_c_tag.full_z) w_cell_z = CELL_W'(w_grid_m1);
        else                     w_cell_z = CELL_W'(w_c_quo_z);
    end

    // output register and skid entry
    logic [FLOOR_W-1:0] r_floor_x, r_floor_z;
    logic [CELL_W-1:0]  r_cell_x, r_cell_z;
    logic               r_degen;
    logic [FLOOR_W-1:0] r_sk_floor_x, r_sk_floor_z;
    logic [CELL_W-1:0]  r_sk_cell_x, r_sk_cell_z;
    logic               r_sk_degen;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_sk_valid  <= 1'b0;
        end else if (r_sk_valid) begin
            if (w_out_acc) begin
                r_out_valid <= 1'b1;
                r_sk_valid  <= 1'b0;
            end
        end else if (!r_out_valid || w_out_acc) begin
            r_out_valid <= w_c_valid;
        end else begin
            r_sk_valid <= w_c_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sk_valid) begin
            if (w_out_acc) begin
                r_floor_x <= r_sk_floor_x;
                r_floor_z <= r_sk_floor_z;
                r_cell_x  <= r_sk_cell_x;
                r_cell_z  <= r_sk_cell_z;
                r_degen   <= r_sk_degen;
            end
        end else if (!r_out_valid || w_out_acc) begin
            r_floor_x <= w_c_tag.fx;
            r_floor_z <= w_c_tag.fz;
            r_cell_x  <= w_cell_x;
            r_cell_z  <= w_cell_z;
            r_degen   <= w_c_tag.degen;
        end else begin
            r_sk_floor_x <= w_c_tag.fx;
            r_sk_floor_z <= w_c_tag.fz;
            r_sk_cell_x  <= w_cell_x;
            r_sk_cell_z  <= w_cell_z;
            r_sk_degen   <= w_c_tag.degen;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_floor_x    = r_floor_x;
    assign o_floor_z    = r_floor_z;
    assign o_cell_x     = r_cell_x;
    assign o_cell_z     = r_cell_z;
    assign o_degenerate = r_degen;

endmodule
